// File: hdl/wia_pkg.sv
`default_nettype none
package wia_pkg;

	localparam int unsigned I64Base = 29;
	localparam logic [5:0] OpWrap = 6'd58;
	localparam logic [5:0] OpExtS = 6'd59;
	localparam logic [5:0] OpExtU = 6'd60;

	typedef enum logic [4:0] {
		OP_EQZ = 5'd0, OP_EQ = 5'd1, OP_NE = 5'd2, OP_LT_S = 5'd3, OP_LT_U = 5'd4,
		OP_GT_S = 5'd5, OP_GT_U = 5'd6, OP_LE_S = 5'd7, OP_LE_U = 5'd8,
		OP_GE_S = 5'd9, OP_GE_U = 5'd10, OP_CLZ = 5'd11, OP_CTZ = 5'd12,
		OP_POPCNT = 5'd13, OP_ADD = 5'd14, OP_SUB = 5'd15, OP_MUL = 5'd16,
		OP_DIV_S = 5'd17, OP_DIV_U = 5'd18, OP_REM_S = 5'd19, OP_REM_U = 5'd20,
		OP_AND = 5'd21, OP_OR = 5'd22, OP_XOR = 5'd23, OP_SHL = 5'd24,
		OP_SHR_S = 5'd25, OP_SHR_U = 5'd26, OP_ROTL = 5'd27, OP_ROTR = 5'd28,
		OP_ZEXT = 5'd29, OP_SEXT = 5'd30, OP_NONE = 5'd31
	} op_t;

	// Classified instruction as it travels from the front end to the back end.
	typedef struct packed {
		op_t         op;
		logic        wide;
		logic [63:0] a;
		logic [63:0] b;
	} instr_t;

endpackage
`default_nettype wire

// File: hdl/wasm_integer_alu_top.sv
// WebAssembly i32/i64 integer ALU.
// Input channel: valid/ready with kind, lhs, rhs. Output channel: valid/ready
// with result and trap. Exactly one output transaction per input transaction,
// in order.
// A two-entry queue decouples the decoder from the execution unit, so input
// is taken while a finished result waits for the receiver.
// i64.mul adds its upper partial products in a second beat, and a non-trapping
// i32 or i64 division or remainder runs the one-bit-per-cycle restoring divider.
// Throughput: one transaction per cycle while the receiver is ready, except
// i64.mul and the non-trapping divisions and remainders, which hold the
// execution unit until their result is ready.
// Reset empties the queue and the output register; no transaction is lost
// when the receiver stalls, the queue fills and then ready drops.
`default_nettype none
module wasm_integer_alu_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [5:0]  kind,
	input  wire logic [63:0] lhs,
	input  wire logic [63:0] rhs,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result,
	output logic             trap
);
	wia_pkg::instr_t dec;
	logic            dec_valid, dec_ready;

	wia_front u_front (.clk, .arst_n, .valid(in_valid), .ready(in_ready), .kind,
		.lhs, .rhs, .dec_valid, .dec_ready, .dec);
	wia_back u_back (.clk, .arst_n, .dec_valid, .dec_ready, .dec, .out_valid,
		.out_ready, .res(result), .trp(trap));
endmodule
`default_nettype wire

// File: hdl/wia_front.sv
`default_nettype none
module wia_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid,
	output logic                ready,
	input  wire logic [5:0]     kind,
	input  wire logic [63:0]    lhs,
	input  wire logic [63:0]    rhs,
	output logic                dec_valid,
	input  wire logic           dec_ready,
	output wia_pkg::instr_t     dec
);
	// Two-entry queue of decoded transactions.
	wia_pkg::instr_t mem_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	wia_pkg::instr_t d;
	logic            push, pop;

	always_comb begin
		d.wide = 1'b0;
		d.op = wia_pkg::OP_NONE;
		if (kind < 6'(wia_pkg::I64Base)) begin
			d.op = wia_pkg::op_t'(kind[4:0]);
		end else if (kind < 6'(2 * wia_pkg::I64Base)) begin
			d.wide = 1'b1;
			d.op = wia_pkg::op_t'(5'(kind - 6'(wia_pkg::I64Base)));
		end else if (kind == wia_pkg::OpWrap || kind == wia_pkg::OpExtU) begin
			d.op = wia_pkg::OP_ZEXT;
		end else if (kind == wia_pkg::OpExtS) begin
			d.op = wia_pkg::OP_SEXT;
		end
		d.a = d.wide ? lhs : {32'd0, lhs[31:0]};
		d.b = d.wide ? rhs : {32'd0, rhs[31:0]};
	end

	assign ready = cnt_q != 2'd2;
	assign push = valid && ready;
	assign dec_valid = cnt_q != 2'd0;
	assign pop = dec_valid && dec_ready;
	assign dec = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !ready) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !dec_valid) else $error("valid from empty queue");
endmodule
`default_nettype wire

// File: hdl/wia_back.sv
`default_nettype none
module wia_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           dec_valid,
	output logic                dec_ready,
	input  wire wia_pkg::instr_t dec,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [63:0]         res,
	output logic                trp
);
	// Division is iterative: one quotient bit per cycle.
	logic [63:0] r;
	logic        t, is_div;
	logic [63:0] m, sb, sa, sbv, ma, mb, shl_v, shr_v, sra_v, sxm;
	logic [5:0]  s, sinv;
	logic        na, nb;
	logic [6:0]  clz_v, ctz_v, pop_v;
	logic        ovf;
	logic        vq, busy_q, rem_q, neg_q, wide_q;
	logic [63:0] q_q, rm_q, dv_q, rq;
	logic [63:0] q_nx, rm_nx;
	logic [6:0]  it_q;
	logic [64:0] trial;
	logic [63:0] mul_lo;

	always_comb begin
		m = dec.wide ? '1 : 64'h0000_0000_ffff_ffff;
		sb = dec.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
		sa = dec.a ^ sb;
		sbv = dec.b ^ sb;
		na = (dec.a & sb) != 0;
		nb = (dec.b & sb) != 0;
		ma = na ? ((~dec.a + 64'd1) & m) : dec.a;
		mb = nb ? ((~dec.b + 64'd1) & m) : dec.b;
		s = dec.wide ? dec.b[5:0] : {1'b0, dec.b[4:0]};
		sinv = (dec.wide ? 6'd0 : 6'd32) - s;
		sinv = dec.wide ? sinv : {1'b0, sinv[4:0]};
		shl_v = (dec.a << s) & m;
		shr_v = dec.a >> s;
		sxm = na ? (~(m >> s) & m) : 64'd0;
		sra_v = shr_v | sxm;
		clz_v = 7'd0;
		for (int i = 0; i < 64; i++) begin
			if (dec.a[i]) clz_v = 7'(63 - i);
		end
		if (!dec.wide) clz_v = (dec.a[31:0] == 0) ? 7'd32 : clz_v - 7'd32;
		else if (dec.a == 0) clz_v = 7'd64;
		ctz_v = dec.wide ? 7'd64 : 7'd32;
		for (int i = 63; i >= 0; i--) begin
			if (dec.a[i]) ctz_v = 7'(i);
		end
		pop_v = 7'd0;
		for (int i = 0; i < 64; i++) pop_v = pop_v + 7'(dec.a[i]);
		mul_lo = dec.a[31:0] * dec.b[31:0];
		ovf = dec.op == wia_pkg::OP_DIV_S && dec.a == sb && dec.b == m;
		is_div = dec.op inside {wia_pkg::OP_DIV_S, wia_pkg::OP_DIV_U,
			wia_pkg::OP_REM_S, wia_pkg::OP_REM_U} && dec.b != 0 && !ovf;
		t = 1'b0;
		r = 64'd0;
		case (dec.op)
			wia_pkg::OP_EQZ: r = 64'(dec.a == 0);
			wia_pkg::OP_EQ: r = 64'(dec.a == dec.b);
			wia_pkg::OP_NE: r = 64'(dec.a != dec.b);
			wia_pkg::OP_LT_S: r = 64'(sa < sbv);
			wia_pkg::OP_LT_U: r = 64'(dec.a < dec.b);
			wia_pkg::OP_GT_S: r = 64'(sa > sbv);
			wia_pkg::OP_GT_U: r = 64'(dec.a > dec.b);
			wia_pkg::OP_LE_S: r = 64'(sa <= sbv);
			wia_pkg::OP_LE_U: r = 64'(dec.a <= dec.b);
			wia_pkg::OP_GE_S: r = 64'(sa >= sbv);
			wia_pkg::OP_GE_U: r = 64'(dec.a >= dec.b);
			wia_pkg::OP_CLZ: r = 64'(clz_v);
			wia_pkg::OP_CTZ: r = 64'(ctz_v);
			wia_pkg::OP_POPCNT: r = 64'(pop_v);
			wia_pkg::OP_ADD: r = (dec.a + dec.b) & m;
			wia_pkg::OP_SUB: r = (dec.a - dec.b) & m;
			wia_pkg::OP_MUL: r = mul_lo & m;
			wia_pkg::OP_DIV_S, wia_pkg::OP_DIV_U, wia_pkg::OP_REM_U:
				t = dec.b == 0 || ovf;
			wia_pkg::OP_REM_S: t = dec.b == 0;
			wia_pkg::OP_AND: r = dec.a & dec.b;
			wia_pkg::OP_OR: r = dec.a | dec.b;
			wia_pkg::OP_XOR: r = dec.a ^ dec.b;
			wia_pkg::OP_SHL: r = shl_v;
			wia_pkg::OP_SHR_S: r = sra_v;
			wia_pkg::OP_SHR_U: r = shr_v;
			wia_pkg::OP_ROTL: r = (shl_v | (dec.a >> sinv)) & m;
			wia_pkg::OP_ROTR: r = (shr_v | (dec.a << sinv)) & m;
			wia_pkg::OP_ZEXT: r = {32'd0, dec.a[31:0]};
			wia_pkg::OP_SEXT: r = {{32{dec.a[31]}}, dec.a[31:0]};
			default: r = 64'd0;
		endcase
	end

	// A 64-bit multiply takes a second beat that adds the upper partial products.
	logic        mulw_q;
	logic [63:0] mlo_q, mx_q;
	logic        mul_wide;
	assign mul_wide = dec.op == wia_pkg::OP_MUL && dec.wide;

	assign trial = {rm_q, q_q[63]} - {1'b0, dv_q};
	assign rm_nx = trial[64] ? {rm_q[62:0], q_q[63]} : trial[63:0];
	assign q_nx = {q_q[62:0], !trial[64]};
	assign rq = neg_q ? (~(rem_q ? rm_nx : q_nx) + 64'd1) : (rem_q ? rm_nx : q_nx);

	assign dec_ready = !busy_q && !mulw_q && (!vq || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq <= 1'b0;
			busy_q <= 1'b0;
			mulw_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) vq <= 1'b0;
			if (busy_q) begin
				if (it_q == 7'd0) begin
					busy_q <= 1'b0;
					vq <= 1'b1;
				end
			end else if (mulw_q) begin
				mulw_q <= 1'b0;
				vq <= 1'b1;
			end else if (dec_valid && dec_ready) begin
				if (is_div) busy_q <= 1'b1;
				else if (mul_wide) mulw_q <= 1'b1;
				else vq <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rm_q <= rm_nx;
			q_q <= q_nx;
			it_q <= it_q - 7'd1;
			if (it_q == 7'd0) begin
				res <= wide_q ? rq : {32'd0, rq[31:0]};
				trp <= 1'b0;
			end
		end else if (mulw_q) begin
			res <= mlo_q + {mx_q[31:0], 32'd0};
			trp <= 1'b0;
		end else if (dec_valid && dec_ready) begin
			res <= r;
			trp <= t;
			rem_q <= dec.op == wia_pkg::OP_REM_S || dec.op == wia_pkg::OP_REM_U;
			wide_q <= dec.wide;
			mlo_q <= mul_lo;
			mx_q <= dec.a[63:32] * dec.b[31:0] + dec.a[31:0] * dec.b[63:32];
			if (dec.op == wia_pkg::OP_DIV_S || dec.op == wia_pkg::OP_REM_S) begin
				q_q <= dec.wide ? ma : {ma[31:0], 32'd0};
				dv_q <= mb;
				neg_q <= (dec.op == wia_pkg::OP_DIV_S) ? (na != nb) : na;
			end else begin
				q_q <= dec.wide ? dec.a : {dec.a[31:0], 32'd0};
				dv_q <= dec.b;
				neg_q <= 1'b0;
			end
			rm_q <= 64'd0;
			it_q <= dec.wide ? 7'd63 : 7'd31;
		end
	end

	assign out_valid = vq && !busy_q && !mulw_q;

	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && mulw_q)) else $error("divider and multiplier both busy");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !dec_ready) else $error("accepted while dividing");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && it_q == 7'd0 |=> out_valid) else $error("division result lost");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned RandomItems = 1100;

	// Evaluates one integer op at width w (32 or 64), first masking the operands to w bits.
	function automatic void int_op(wia_pkg::op_t op, logic [63:0] a, logic [63:0] b, int w,
		output logic [63:0] v, output logic t);
		logic [63:0] m, sb, ma, mb, q, r, sa, sbv;
		logic        na, nb;
		int          s, n;
		m = (w == 64) ? '1 : 64'h0000_0000_ffff_ffff;
		sb = 64'd1 << (w - 1);
		a &= m;
		b &= m;
		sa = a ^ sb;
		sbv = b ^ sb;
		s = int'(b & 64'(w - 1));
		na = (a & sb) != 0;
		nb = (b & sb) != 0;
		ma = na ? ((~a + 64'd1) & m) : a;
		mb = nb ? ((~b + 64'd1) & m) : b;
		v = '0;
		t = 1'b0;
		case (op)
			wia_pkg::OP_EQZ: v = 64'(a == 0);
			wia_pkg::OP_EQ: v = 64'(a == b);
			wia_pkg::OP_NE: v = 64'(a != b);
			wia_pkg::OP_LT_S: v = 64'(sa < sbv);
			wia_pkg::OP_LT_U: v = 64'(a < b);
			wia_pkg::OP_GT_S: v = 64'(sa > sbv);
			wia_pkg::OP_GT_U: v = 64'(a > b);
			wia_pkg::OP_LE_S: v = 64'(sa <= sbv);
			wia_pkg::OP_LE_U: v = 64'(a <= b);
			wia_pkg::OP_GE_S: v = 64'(sa >= sbv);
			wia_pkg::OP_GE_U: v = 64'(a >= b);
			wia_pkg::OP_CLZ: begin
				n = 0;
				while (n < w && !a[w - 1 - n])
					n++;
				v = 64'(n);
			end
			wia_pkg::OP_CTZ: begin
				n = 0;
				while (n < w && !a[n])
					n++;
				v = 64'(n);
			end
			wia_pkg::OP_POPCNT: v = 64'($countones(a));
			wia_pkg::OP_ADD: v = (a + b) & m;
			wia_pkg::OP_SUB: v = (a - b) & m;
			wia_pkg::OP_MUL: v = (a * b) & m;
			wia_pkg::OP_DIV_S: begin
				if (b == 0 || (a == sb && b == m))
					t = 1'b1;
				else begin
					q = ma / mb;
					v = ((na != nb) ? (~q + 64'd1) : q) & m;
				end
			end
			wia_pkg::OP_DIV_U: begin
				if (b == 0)
					t = 1'b1;
				else
					v = a / b;
			end
			wia_pkg::OP_REM_S: begin
				if (b == 0)
					t = 1'b1;
				else begin
					r = ma % mb;
					v = (na ? (~r + 64'd1) : r) & m;
				end
			end
			wia_pkg::OP_REM_U: begin
				if (b == 0)
					t = 1'b1;
				else
					v = a % b;
			end
			wia_pkg::OP_AND: v = a & b;
			wia_pkg::OP_OR: v = a | b;
			wia_pkg::OP_XOR: v = a ^ b;
			wia_pkg::OP_SHL: v = (a << s) & m;
			wia_pkg::OP_SHR_S: v = na ? ((a >> s) | (~(m >> s) & m)) : (a >> s);
			wia_pkg::OP_SHR_U: v = a >> s;
			wia_pkg::OP_ROTL: v = ((a << s) | (a >> ((w - s) & (w - 1)))) & m;
			wia_pkg::OP_ROTR: v = ((a >> s) | (a << ((w - s) & (w - 1)))) & m;
			default: v = '0;
		endcase
	endfunction

	function automatic void alu_evaluate(logic [5:0] code, logic [63:0] a, logic [63:0] b,
		output logic [63:0] v, output logic t);
		v = '0;
		t = 1'b0;
		if (code < wia_pkg::I64Base)
			int_op(wia_pkg::op_t'(code[4:0]), a, b, 32, v, t);
		else if (code < 2 * wia_pkg::I64Base)
			int_op(wia_pkg::op_t'(5'(code - wia_pkg::I64Base)), a, b, 64, v, t);
		else if (code == wia_pkg::OpWrap || code == wia_pkg::OpExtU)
			v = {32'd0, a[31:0]};
		else if (code == wia_pkg::OpExtS)
			v = {{32{a[31]}}, a[31:0]};
	endfunction

	class alu_scoreboard;
		logic [63:0] want_value[$];
		logic        want_trap[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned traps_seen;

		function new();
			mismatches = 0;
			checked = 0;
			traps_seen = 0;
		endfunction

		function void note_instruction(logic [5:0] code, logic [63:0] a, logic [63:0] b);
			logic [63:0] v;
			logic        t;
			alu_evaluate(code, a, b, v, t);
			want_value.push_back(v);
			want_trap.push_back(t);
		endfunction

		function void check_result(logic [63:0] got_value, logic got_trap);
			logic [63:0] v;
			logic        t;
			if (want_value.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: result=%h trap=%b",
						got_value, got_trap);
				return;
			end
			v = want_value.pop_front();
			t = want_trap.pop_front();
			checked++;
			if (t)
				traps_seen++;
			if (v !== got_value || t !== got_trap) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at result %0d: expected %h/%b, got %h/%b",
						checked, v, t, got_value, got_trap);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [5:0]  kind = 0;
	logic [63:0] lhs = 0;
	logic [63:0] rhs = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] result;
	logic        trap;

	alu_scoreboard board;
	int unsigned   cycles = 0;
	int unsigned   sent = 0;
	bit            hold_off = 0;

	wasm_integer_alu_top dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(result, trap);
	end

	// Receiver stalls: a repeating pattern, plus one long hold-off when asked.
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 0;
		else if ((cycles % 64) < 16)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return {$urandom, 32'h8000_0000};
			4: return 64'($urandom_range(0, 70));
			5: return {32'hffff_ffff, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offers one instruction and holds it until the transaction completes.
	task automatic send_instruction(logic [5:0] code, logic [63:0] a, logic [63:0] b);
		kind <= code;
		lhs <= a;
		rhs <= b;
		in_valid <= 1;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_instruction(code, a, b);
		sent++;
	endtask

	task automatic pause_sender();
		in_valid <= 0;
		repeat ($urandom_range(1, 5))
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] mn;
		int          burst;
		board = new();
		repeat (7)
			@(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed corners: division traps, remainder overflow, zero counts,
		// large shift counts, ignored upper bits and unused codes.
		for (int wide = 0; wide < 2; wide++) begin
			mn = wide ? 64'h8000_0000_0000_0000 : 64'hffff_ffff_8000_0000;
			send_instruction(6'(wia_pkg::OP_DIV_S + wide * wia_pkg::I64Base), mn, '1);
			send_instruction(6'(wia_pkg::OP_REM_S + wide * wia_pkg::I64Base), mn, '1);
			send_instruction(6'(wia_pkg::OP_DIV_U + wide * wia_pkg::I64Base), '1,
				64'hffff_ffff_0000_0000);
			send_instruction(6'(wia_pkg::OP_REM_U + wide * wia_pkg::I64Base), 64'd5, 64'd0);
			send_instruction(6'(wia_pkg::OP_CLZ + wide * wia_pkg::I64Base),
				64'hffff_ffff_0000_0000, 64'd0);
			send_instruction(6'(wia_pkg::OP_CTZ + wide * wia_pkg::I64Base), 64'd0, '1);
			send_instruction(6'(wia_pkg::OP_ROTR + wide * wia_pkg::I64Base),
				64'h1234_5678_9abc_def1, 64'd127);
			send_instruction(6'(wia_pkg::OP_SHR_S + wide * wia_pkg::I64Base), mn, 64'd95);
			send_instruction(6'(wia_pkg::OP_LE_U + wide * wia_pkg::I64Base), '1, 64'd1);
		end
		send_instruction(wia_pkg::OpWrap, '1, 64'd0);
		send_instruction(wia_pkg::OpExtS, 64'h0000_0000_8000_0001, 64'd0);
		send_instruction(wia_pkg::OpExtU, 64'hffff_ffff_ffff_ffff, 64'd0);
		send_instruction(6'd61, '1, '1);
		send_instruction(6'd63, '1, '1);

		// Long receiver hold-off while the sender keeps offering work.
		fork
			begin
				hold_off = 1;
				repeat (40)
					@(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 12; i++)
				send_instruction(6'(wia_pkg::OP_ADD + wia_pkg::I64Base), pick_operand(),
					pick_operand());
		join

		while (sent < RandomItems + 35) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst; i++)
				send_instruction(6'($urandom_range(0, 63)), pick_operand(), pick_operand());
			if ($urandom_range(0, 2) != 0)
				pause_sender();
		end
		in_valid <= 0;

		while (board.want_value.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		$display("covered %0d instructions over all codes, %0d traps among %0d results",
			sent, board.traps_seen, board.checked);
		if (board.mismatches == 0)
			$display("tb: success");
		else begin
			$display("%0d mismatches", board.mismatches);
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
